/* src/tbp_pkg.sv */
// package with shared constants, register codes and state type of the three-hash bin placer
`default_nettype none

package tbp_pkg;

    localparam int HASH_W       = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int BIN_COUNT_W  = 13;
    localparam int MAX_FILL_W   = 6;
    localparam int ADDR_OUT_W   = 12;
    localparam int SLOT_OUT_W   = 5;
    localparam int CHOICE_W     = 2;
    localparam int ELEM_OUT_W   = 20;
    localparam int TOTAL_W      = 22;
    localparam int MOD_STEPS    = 4;

    localparam int DEF_BINS         = 4096;
    localparam int DEF_SLOTS        = 32;
    localparam int DEF_ELEMENT_BITS = 20;

    localparam logic [TOTAL_W-1:0]     PLACE_MAX     = 22'd3145728;
    localparam logic [CFG_IDX_W-1:0]   REG_BIN_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0]   REG_MAX_FILL  = 2'd1;
    localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RST = 13'd4096;
    localparam logic [MAX_FILL_W-1:0]  MAX_FILL_RST  = 6'd32;
    localparam logic [CHOICE_W-1:0]    CHOICE_FIRST  = 2'd0;
    localparam logic [CHOICE_W-1:0]    CHOICE_SECOND = 2'd1;
    localparam logic [CHOICE_W-1:0]    CHOICE_LAST   = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_WRITE
    } state_t;

endpackage

`default_nettype wire

/* src/tbp_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module tbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/tbp_mod.sv */
// iterative remainder unit, MOD_STEPS dividend bits per cycle
`default_nettype none

module tbp_mod (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [tbp_pkg::HASH_W-1:0]      dividend,
    input  wire logic [tbp_pkg::BIN_COUNT_W-1:0] modulus,
    output logic                                 done,
    output logic      [tbp_pkg::BIN_COUNT_W-1:0] remainder
);

    import tbp_pkg::*;

    localparam int ITERS = HASH_W / MOD_STEPS;
    localparam int CW    = $clog2(ITERS);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CW-1:0]          cnt_reg;
    logic [HASH_W-1:0]      dvd_reg;
    logic [BIN_COUNT_W-1:0] rem_reg;
    logic [BIN_COUNT_W-1:0] rem_next;

    always_comb
    begin
        logic [BIN_COUNT_W-1:0] r;
        logic [BIN_COUNT_W:0]   t;
        r = rem_reg;
        t = '0;
        for (int i = 0; i < MOD_STEPS; i++)
        begin
            t = {r, dvd_reg[HASH_W-1-i]};
            if (t >= {1'b0, modulus})
            begin
                t = t - {1'b0, modulus};
            end
            r = t[BIN_COUNT_W-1:0];
        end
        rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(ITERS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << MOD_STEPS;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < modulus))
        else $error("remainder not below modulus");

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("done while still busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("start did not begin a reduction");

endmodule

`default_nettype wire

/* src/three_hash_bin_placer_top.sv */
// top level of the three-hash bin placer: control, counters, fill and contents memories
`default_nettype none

// Each input transaction carries three 64-bit hashes of one element and yields three result
// transactions, one per hash in order, each giving the bin (hash modulo bin_count, with the
// count clamped to 1..BINS), the slot taken, or an overflow flag when the bin was already at
// max_bin_fill (clamped to 1..SLOTS_PER_BIN). After reset the block sweeps the fill memory,
// one bin per cycle, while in_stall stays high; configuration writes are taken at any time.
// The three hashes share one remainder unit that retires 4 dividend bits per cycle, followed
// by a read and a write of the bin's fill counter in a one-port-read memory. A finished result
// sits in an output register, so the next item is taken while it waits.
module three_hash_bin_placer_top #(
    parameter int BINS          = tbp_pkg::DEF_BINS,
    parameter int SLOTS_PER_BIN = tbp_pkg::DEF_SLOTS,
    parameter int ELEMENT_BITS  = tbp_pkg::DEF_ELEMENT_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tbp_pkg::CFG_DATA_W-1:0] cfg_data,

    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [tbp_pkg::HASH_W-1:0]     hash_first,
    input  wire logic [tbp_pkg::HASH_W-1:0]     hash_second,
    input  wire logic [tbp_pkg::HASH_W-1:0]     hash_third,
    input  wire logic                           start_batch,

    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [tbp_pkg::ADDR_OUT_W-1:0] bin_address,
    output logic      [tbp_pkg::SLOT_OUT_W-1:0] slot_number,
    output logic      [tbp_pkg::CHOICE_W-1:0]   hash_choice,
    output logic      [tbp_pkg::ELEM_OUT_W-1:0] element_number,
    output logic                                overflow,
    output logic      [tbp_pkg::TOTAL_W-1:0]    placements_total,
    output logic                                last
);

    import tbp_pkg::*;

    localparam int AW    = $clog2(BINS);
    localparam int FW    = $clog2(SLOTS_PER_BIN + 1);
    localparam int CAW   = $clog2(BINS * SLOTS_PER_BIN);
    localparam int EW    = ELEMENT_BITS;
    localparam int CTW   = ELEMENT_BITS + CHOICE_W;
    localparam logic [AW-1:0] CLR_LAST = AW'(BINS - 1);

    // configuration
    logic [BIN_COUNT_W-1:0] bin_count_reg;
    logic [MAX_FILL_W-1:0]  max_fill_reg;
    logic [BIN_COUNT_W-1:0] modulus;
    logic [FW-1:0]          limit;

    // control
    state_t         state_reg;
    state_t         state_next;
    logic [AW-1:0]  clear_cnt_reg;
    logic [CHOICE_W-1:0] k_reg;
    logic [EW-1:0]  elem_reg;
    logic [TOTAL_W-1:0] place_reg;
    logic [TOTAL_W-1:0] place_upd;
    logic           accept;
    logic           out_free;
    logic           write_go;
    logic           fits;

    // payload
    logic [HASH_W-1:0] h0_reg;
    logic [HASH_W-1:0] h1_reg;
    logic [HASH_W-1:0] h2_reg;
    logic [AW-1:0]     addr_reg;

    // remainder unit
    logic                   mod_start;
    logic [HASH_W-1:0]      mod_dividend;
    logic                   mod_done;
    logic [BIN_COUNT_W-1:0] mod_rem;

    // memories
    logic           fill_wr_en;
    logic [AW-1:0]  fill_wr_addr;
    logic [FW-1:0]  fill_wr_data;
    logic           fill_rd_en;
    logic [FW-1:0]  fill_rd_data;
    logic           cont_wr_en;
    logic [CAW-1:0] cont_wr_addr;
    logic [CTW-1:0] cont_wr_data;

    // result register
    logic                  out_valid_reg;
    logic [ADDR_OUT_W-1:0] out_addr_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;
    logic [CHOICE_W-1:0]   out_choice_reg;
    logic [ELEM_OUT_W-1:0] out_elem_reg;
    logic                  out_ovf_reg;
    logic [TOTAL_W-1:0]    out_total_reg;
    logic                  out_last_reg;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (bin_count_reg == '0)
        begin
            modulus = BIN_COUNT_W'(1);
        end
        else if (32'(bin_count_reg) > 32'(BINS))
        begin
            modulus = BIN_COUNT_W'(BINS);
        end
        else
        begin
            modulus = bin_count_reg;
        end
    end

    always_comb
    begin
        if (max_fill_reg == '0)
        begin
            limit = FW'(1);
        end
        else if (32'(max_fill_reg) > 32'(SLOTS_PER_BIN))
        begin
            limit = FW'(SLOTS_PER_BIN);
        end
        else
        begin
            limit = FW'(max_fill_reg);
        end
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign accept    = (state_reg == ST_IDLE) && in_valid;
    assign write_go  = (state_reg == ST_WRITE) && out_free;
    assign fits      = fill_rd_data < limit;
    assign place_upd = (fits && (place_reg < PLACE_MAX)) ? place_reg + TOTAL_W'(1) : place_reg;

    always_comb
    begin
        unique case (k_reg)
            CHOICE_FIRST:  mod_dividend = h0_reg;
            CHOICE_SECOND: mod_dividend = h1_reg;
            default:       mod_dividend = h2_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (mod_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = (k_reg == CHOICE_LAST) ? ST_IDLE : ST_START;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        in_stall     = 1'b1;
        mod_start    = 1'b0;
        fill_rd_en   = 1'b0;
        fill_wr_en   = 1'b0;
        fill_wr_addr = addr_reg;
        fill_wr_data = fill_rd_data + FW'(1);
        cont_wr_en   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                fill_wr_en   = 1'b1;
                fill_wr_addr = clear_cnt_reg;
                fill_wr_data = '0;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_START:
            begin
                mod_start = 1'b1;
            end
            ST_DIV:
            begin
                fill_rd_en = mod_done;
            end
            ST_WRITE:
            begin
                fill_wr_en = out_free && fits;
                cont_wr_en = out_free && fits;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign cont_wr_addr = CAW'(addr_reg) * CAW'(SLOTS_PER_BIN) + CAW'(fill_rd_data);
    assign cont_wr_data = {elem_reg, k_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
            bin_count_reg <= BIN_COUNT_RST;
            max_fill_reg  <= MAX_FILL_RST;
            k_reg         <= CHOICE_FIRST;
            elem_reg      <= '0;
            place_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clear_cnt_reg <= clear_cnt_reg + AW'(1);
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_BIN_COUNT: bin_count_reg <= cfg_data[BIN_COUNT_W-1:0];
                    REG_MAX_FILL:  max_fill_reg  <= cfg_data[MAX_FILL_W-1:0];
                    default:       bin_count_reg <= bin_count_reg;
                endcase
            end
            if (accept)
            begin
                k_reg <= CHOICE_FIRST;
                if (start_batch)
                begin
                    elem_reg  <= '0;
                    place_reg <= '0;
                end
            end
            else if (write_go)
            begin
                k_reg     <= k_reg + CHOICE_W'(1);
                place_reg <= place_upd;
                if (k_reg == CHOICE_LAST)
                begin
                    elem_reg <= elem_reg + EW'(1);
                end
            end
            if (write_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            h0_reg <= hash_first;
            h1_reg <= hash_second;
            h2_reg <= hash_third;
        end
        if (mod_done)
        begin
            addr_reg <= AW'(mod_rem);
        end
        if (write_go)
        begin
            out_addr_reg   <= ADDR_OUT_W'(addr_reg);
            out_slot_reg   <= fits ? SLOT_OUT_W'(fill_rd_data) : '0;
            out_choice_reg <= k_reg;
            out_elem_reg   <= ELEM_OUT_W'(elem_reg);
            out_ovf_reg    <= !fits;
            out_total_reg  <= place_upd;
            out_last_reg   <= (k_reg == CHOICE_LAST);
        end
    end

    tbp_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .modulus   (modulus),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    tbp_ram #(
        .WIDTH (FW),
        .DEPTH (BINS)
    ) u_fill_ram (
        .clk     (clk),
        .wr_en   (fill_wr_en),
        .wr_addr (fill_wr_addr),
        .wr_data (fill_wr_data),
        .rd_en   (fill_rd_en),
        .rd_addr (AW'(mod_rem)),
        .rd_data (fill_rd_data)
    );

    tbp_ram #(
        .WIDTH (CTW),
        .DEPTH (BINS * SLOTS_PER_BIN)
    ) u_contents_ram (
        .clk     (clk),
        .wr_en   (cont_wr_en),
        .wr_addr (cont_wr_addr),
        .wr_data (cont_wr_data),
        .rd_en   (1'b0),
        .rd_addr ('0),
        .rd_data ()
    );

    assign out_valid        = out_valid_reg;
    assign bin_address      = out_addr_reg;
    assign slot_number      = out_slot_reg;
    assign hash_choice      = out_choice_reg;
    assign element_number   = out_elem_reg;
    assign overflow         = out_ovf_reg;
    assign placements_total = out_total_reg;
    assign last             = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_ovf_reg && (out_slot_reg != '0)))
        else $error("overflow transaction with nonzero slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_last_reg == (out_choice_reg == CHOICE_LAST)))
        else $error("last flag out of step with hash choice");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_total_reg <= PLACE_MAX))
        else $error("placement total beyond saturation");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_wr_en && (state_reg == ST_WRITE)) |-> (fill_rd_data < limit))
        else $error("fill counter advanced past limit");

endmodule

`default_nettype wire
